// ===== rtl/core/pbd_pkg.sv =====
`default_nettype none

package pbd_pkg;

    localparam int RES_DEPTH_DEFAULT = 4;
    localparam logic [15:0] LIMIT_RESET = 16'd30000;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Bundle status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
    localparam logic [2:0] ST_OVER_LIMIT  = 3'd2;
    localparam logic [2:0] ST_TRUNC_LEN   = 3'd3;
    localparam logic [2:0] ST_TRUNC_DATA  = 3'd4;

    // Configuration register indexes
    localparam logic REG_COUNT_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] packet_number;
        logic        packet_end;
        logic [2:0]  bundle_status;
        logic        result_last;
    } result_t;

    // Results produced by one accepted byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/pbd_parser.sv =====
`default_nettype none

module pbd_parser
    import pbd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        bundle_last,
    input  wire logic [15:0] packet_count_limit,
    output push_t            push
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_PADDING = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    logic [2:0]  phase_reg,  phase_next;
    logic [1:0]  hdr_pos_reg, hdr_pos_next;
    logic [31:0] count_reg,  count_next;
    logic [15:0] done_reg,   done_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remain_reg, remain_next;
    logic [2:0]  error_reg,  error_next;

    logic [15:0] done_inc;
    logic [15:0] length_full;
    logic        have_data;
    result_t     data_res;
    result_t     status_res;

    assign done_inc    = done_reg + 16'd1;
    assign length_full = {len_hi_reg, data_byte};

    always_comb begin
        phase_next   = phase_reg;
        hdr_pos_next = hdr_pos_reg;
        count_next   = count_reg;
        done_next    = done_reg;
        len_hi_next  = len_hi_reg;
        remain_next  = remain_reg;
        error_next   = error_reg;
        have_data    = 1'b0;
        data_res     = '0;
        status_res   = '0;
        push         = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                count_next   = {count_reg[23:0], data_byte};
                hdr_pos_next = hdr_pos_reg + 2'd1;
                if (hdr_pos_reg == 2'd3) begin
                    if (count_next > {16'd0, packet_count_limit}) begin
                        phase_next = PH_ERROR;
                        error_next = ST_OVER_LIMIT;
                    end else if (count_next == 32'd0) begin
                        phase_next = PH_PADDING;
                    end else begin
                        phase_next = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI: begin
                len_hi_next = data_byte;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (length_full == 16'd0) begin
                    have_data              = 1'b1;
                    data_res.result_kind   = KIND_EMPTY;
                    data_res.packet_number = done_reg;
                    data_res.packet_end    = 1'b1;
                    done_next              = done_inc;
                    phase_next = ({16'd0, done_inc} >= count_reg) ? PH_PADDING : PH_LEN_HI;
                end else begin
                    remain_next = length_full;
                    phase_next  = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                have_data              = 1'b1;
                data_res.result_kind   = KIND_PAYLOAD;
                data_res.payload_byte  = data_byte;
                data_res.packet_number = done_reg;
                data_res.packet_end    = (remain_reg == 16'd1);
                remain_next            = remain_reg - 16'd1;
                if (remain_reg == 16'd1) begin
                    done_next  = done_inc;
                    phase_next = ({16'd0, done_inc} >= count_reg) ? PH_PADDING : PH_LEN_HI;
                end
            end
            default: begin
            end
        endcase

        // The status reflects the phase reached after this byte was parsed.
        status_res.result_kind   = KIND_STATUS;
        status_res.result_last   = 1'b1;
        status_res.packet_number = count_next[15:0];
        unique case (phase_next)
            PH_HEADER: begin
                status_res.bundle_status = ST_SHORT_HDR;
                status_res.packet_number = 16'd0;
            end
            PH_LEN_HI, PH_LEN_LO: status_res.bundle_status = ST_TRUNC_LEN;
            PH_PAYLOAD:           status_res.bundle_status = ST_TRUNC_DATA;
            PH_ERROR:             status_res.bundle_status = error_next;
            default:              status_res.bundle_status = ST_OK;
        endcase

        if (in_accept) begin
            if (have_data) begin
                push.first = data_res;
                if (bundle_last) begin
                    push.second = status_res;
                    push.count  = 2'd2;
                end else begin
                    push.count = 2'd1;
                end
            end else if (bundle_last) begin
                push.first = status_res;
                push.count = 2'd1;
            end
        end

        if (!in_accept) begin
            phase_next   = phase_reg;
            hdr_pos_next = hdr_pos_reg;
            count_next   = count_reg;
            done_next    = done_reg;
            len_hi_next  = len_hi_reg;
            remain_next  = remain_reg;
            error_next   = error_reg;
        end else if (bundle_last) begin
            phase_next   = PH_HEADER;
            hdr_pos_next = 2'd0;
            count_next   = '0;
            done_next    = '0;
            len_hi_next  = '0;
            remain_next  = '0;
            error_next   = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_pos_reg <= '0;
            count_reg   <= '0;
            done_reg    <= '0;
            len_hi_reg  <= '0;
            remain_reg  <= '0;
            error_reg   <= ST_OK;
        end else begin
            phase_reg   <= phase_next;
            hdr_pos_reg <= hdr_pos_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            len_hi_reg  <= len_hi_next;
            remain_reg  <= remain_next;
            error_reg   <= error_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pbd_result_fifo.sv =====
`default_nettype none

module pbd_result_fifo
    import pbd_pkg::*;
#(
    parameter int RES_DEPTH = RES_DEPTH_DEFAULT,
    localparam int PW = $clog2(RES_DEPTH),
    localparam int LW = $clog2(RES_DEPTH + 1)
)(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  push_t        push,
    input  wire logic    pop,
    output result_t      head,
    output logic [LW-1:0] level
);

    // Depth must be a power of two; pointers wrap by overflow.
    result_t        entry_reg [RES_DEPTH];
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [LW-1:0]  level_reg,  level_next;
    logic [PW-1:0]  wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + PW'(1);
    assign rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
    assign wr_ptr_next = wr_ptr_reg + PW'(push.count);
    assign level_next  = level_reg + LW'(push.count) - LW'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule

`default_nettype wire

// ===== rtl/core/packet_bundle_deframer.sv =====
// Length-prefixed packet bundle deframer. Bundle bytes enter on the s_ stream one
// per cycle while s_tready is high; each byte is parsed in the cycle it is accepted
// and its results (a payload byte, an empty-packet marker, and on the last bundle
// byte a status) are written into a small result queue that drives the m_ stream
// one result per cycle while m_tready is high, the cycle after acceptance at the
// earliest. The block takes one byte per cycle while two or more queue slots are
// free; only the last byte of a bundle that also carries payload or a marker yields
// two results, and s_tready drops while the queue has fewer than two free slots.
// Payload already delivered is not retracted on an error: the consumer drops the
// bundle when the closing status is not ok.
`default_nettype none

module packet_bundle_deframer
    import pbd_pkg::*;
#(
    parameter int RES_DEPTH = RES_DEPTH_DEFAULT
)(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // bundle_last

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] payload_byte, [23:8] packet_number, [24] packet_end,
    // [27:25] bundle_status, [31:28] zero
    output logic [31:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    output logic             m_tlast,   // result_last

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LW = $clog2(RES_DEPTH + 1);

    logic [15:0]   limit_reg;
    logic          in_accept;
    logic          out_pop;
    push_t         push;
    result_t       head;
    logic [LW-1:0] level;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_COUNT_LIMIT) begin
            limit_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_COUNT_LIMIT) ? {16'd0, limit_reg} : 32'd0;

    assign s_tready  = (level <= LW'(RES_DEPTH - 2));
    assign in_accept = s_tvalid && s_tready;
    assign out_pop   = m_tvalid && m_tready;

    pbd_parser u_parser (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_accept          (in_accept),
        .data_byte          (s_tdata),
        .bundle_last        (s_tlast),
        .packet_count_limit (limit_reg),
        .push               (push)
    );

    pbd_result_fifo #(
        .RES_DEPTH (RES_DEPTH)
    ) u_result_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (out_pop),
        .head    (head),
        .level   (level)
    );

    assign m_tvalid = (level != '0);
    assign m_tdata  = {4'd0, head.bundle_status, head.packet_end,
                       head.packet_number, head.payload_byte};
    assign m_tuser  = head.result_kind;
    assign m_tlast  = head.result_last;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LW'(RES_DEPTH))
        else $error("result queue level exceeds its depth");

    a_last_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_tlast |=> m_tvalid)
        else $error("bundle end accepted but no status queued");

    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("result_last does not match a status result");

    a_status_only_on_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_STATUS |-> m_tdata[27:25] == ST_OK)
        else $error("nonzero bundle status on a packet result");

endmodule

`default_nettype wire

// ===== verif/packet_bundle_deframer_tb.sv =====
`timescale 1ns / 1ps

module packet_bundle_deframer_tb;
    import pbd_pkg::*;

    typedef enum logic [2:0] {
        PS_COUNT,
        PS_LEN_HI,
        PS_LEN_LO,
        PS_PAYLOAD,
        PS_PADDING,
        PS_REJECT
    } parse_state_e;

    localparam logic [2:0] LIMIT_ADDR = {REG_COUNT_LIMIT, 2'b00};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
    logic        s_tlast = 1'b0;    // bundle_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] payload, [23:8] packet number, [24] end, [27:25] status
    logic [1:0]  m_tuser;           // [1:0] result_kind
    logic        m_tlast;           // result_last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    packet_bundle_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the deframer state and its limit register.
    parse_state_e parse_state = PS_COUNT;
    logic [1:0]   hdr_pos = 2'd0;
    logic [31:0]  hdr_count = 32'd0;
    logic [15:0]  pkts_done = 16'd0;
    logic [15:0]  len_acc = 16'd0;
    logic [15:0]  bytes_left = 16'd0;
    logic [2:0]   reject_code = 3'd0;
    logic [15:0]  limit_reg = LIMIT_RESET;

    result_t     predicted_outputs[$];
    logic [7:0]  bundle_q[$];
    int          send_gap_max = 5;
    int          recv_gap_max = 5;
    int          items_sent = 0;
    int          bundles_sent = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          status_seen[8];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void push_expected(logic [1:0] kind, logic [7:0] data, logic [15:0] num,
                                          logic pend, logic [2:0] status, logic last);
        result_t r;
        r.result_kind   = kind;
        r.payload_byte  = data;
        r.packet_number = num;
        r.packet_end    = pend;
        r.bundle_status = status;
        r.result_last   = last;
        predicted_outputs.push_back(r);
    endfunction

    function automatic void clear_bundle();
        parse_state = PS_COUNT;
        hdr_pos     = 2'd0;
        hdr_count   = 32'd0;
        pkts_done   = 16'd0;
        len_acc     = 16'd0;
        bytes_left  = 16'd0;
        reject_code = 3'd0;
    endfunction

    function automatic void finish_packet();
        pkts_done   = pkts_done + 16'd1;
        parse_state = ({16'd0, pkts_done} >= hdr_count) ? PS_PADDING : PS_LEN_HI;
    endfunction

    // Advances the shadow parser by one accepted byte and queues what it yields.
    function automatic void deframe_byte(logic [7:0] data, logic last);
        logic [2:0]  status;
        logic [15:0] num;
        case (parse_state)
            PS_COUNT: begin
                hdr_count = {hdr_count[23:0], data};
                hdr_pos   = hdr_pos + 2'd1;
                if (hdr_pos == 2'd0) begin
                    if (hdr_count > {16'd0, limit_reg}) begin
                        parse_state = PS_REJECT;
                        reject_code = ST_OVER_LIMIT;
                    end else if (hdr_count == 32'd0) begin
                        parse_state = PS_PADDING;
                    end else begin
                        parse_state = PS_LEN_HI;
                    end
                end
            end
            PS_LEN_HI: begin
                len_acc     = {data, 8'h00};
                parse_state = PS_LEN_LO;
            end
            PS_LEN_LO: begin
                len_acc = len_acc | {8'h00, data};
                if (len_acc == 16'd0) begin
                    push_expected(KIND_EMPTY, 8'd0, pkts_done, 1'b1, ST_OK, 1'b0);
                    finish_packet();
                end else begin
                    bytes_left  = len_acc;
                    parse_state = PS_PAYLOAD;
                end
            end
            PS_PAYLOAD: begin
                push_expected(KIND_PAYLOAD, data, pkts_done, bytes_left == 16'd1, ST_OK, 1'b0);
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    finish_packet();
                end
            end
            default: ;
        endcase
        if (last) begin
            num = hdr_count[15:0];
            case (parse_state)
                PS_COUNT: begin
                    status = ST_SHORT_HDR;
                    num    = 16'd0;
                end
                PS_LEN_HI, PS_LEN_LO: status = ST_TRUNC_LEN;
                PS_PAYLOAD: status = ST_TRUNC_DATA;
                PS_REJECT: status = reject_code;
                default: status = ST_OK;
            endcase
            status_seen[status]++;
            push_expected(KIND_STATUS, 8'd0, num, 1'b0, status, 1'b1);
            clear_bundle();
        end
    endfunction

    // Called at a rising edge; returns at the edge where the byte was taken.
    // tvalid is left high so that a following byte can go out without a gap.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        deframe_byte(data, last);
    endtask

    task automatic send_bundle();
        foreach (bundle_q[i]) begin
            send_byte(bundle_q[i], i == bundle_q.size() - 1);
        end
        bundles_sent++;
    endtask

    // Header and padding bytes yield nothing, so the clock keeps running after the queue
    // of expected results is empty, for anything still inside the block.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        limit_reg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_limit_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIMIT_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[15:0] !== limit_reg) begin
            report_mismatch($sformatf("limit readback %0d, expected %0d", prdata[15:0], limit_reg));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void push_count(logic [31:0] c);
        bundle_q.push_back(c[31:24]);
        bundle_q.push_back(c[23:16]);
        bundle_q.push_back(c[15:8]);
        bundle_q.push_back(c[7:0]);
    endfunction

    function automatic void push_random_bytes(int n);
        repeat (n) bundle_q.push_back(8'($urandom()));
    endfunction

    function automatic void build_wellformed(logic [31:0] c);
        logic [15:0] len;
        push_count(c);
        for (int i = 0; i < c; i++) begin
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 48))
                                              : 16'($urandom_range(0, 4));
            bundle_q.push_back(len[15:8]);
            bundle_q.push_back(len[7:0]);
            push_random_bytes(len);
        end
        push_random_bytes($urandom_range(0, 3));
    endfunction

    function automatic void build_random_bundle();
        int          pick;
        int          hi;
        int          cut;
        logic [31:0] c;
        logic [15:0] len;
        bundle_q.delete();
        pick = $urandom_range(0, 99);
        hi   = (limit_reg < 5) ? limit_reg : 5;
        if (pick < 72) begin
            build_wellformed(32'($urandom_range(0, hi)));
            // Some well-formed bundles are cut short anywhere, header included.
            if (pick >= 60 && bundle_q.size() > 1) begin
                cut = $urandom_range(1, bundle_q.size() - 1);
                while (bundle_q.size() > cut) void'(bundle_q.pop_back());
            end
        end else if (pick < 82) begin
            // Full-range length field; the bundle usually ends inside the payload.
            push_count(32'($urandom_range((hi > 0) ? 1 : 0, hi)));
            len = 16'($urandom());
            bundle_q.push_back(len[15:8]);
            bundle_q.push_back(len[7:0]);
            push_random_bytes($urandom_range(0, 6));
        end else if (pick < 92) begin
            c = $urandom_range(0, 1) ? {16'd0, limit_reg} + 32'd1 : 32'($urandom());
            push_count(c);
            push_random_bytes($urandom_range(0, 4));
        end else begin
            push_random_bytes($urandom_range(1, 8));
        end
    endfunction

    // Result side: checks every accepted result and stalls at random.
    always @(posedge aclk) begin : result_sink
        result_t want;
        int      stall;
        int      hold;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d tdata %h last %0d",
                                          m_tuser, m_tdata, m_tlast));
            end else begin
                want = predicted_outputs.pop_front();
                results_checked++;
                if (m_tuser !== want.result_kind)
                    report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                              results_checked, m_tuser, want.result_kind));
                if (m_tdata[7:0] !== want.payload_byte)
                    report_mismatch($sformatf("result %0d payload %h, expected %h",
                                              results_checked, m_tdata[7:0], want.payload_byte));
                if (m_tdata[23:8] !== want.packet_number)
                    report_mismatch($sformatf("result %0d packet number %0d, expected %0d",
                                              results_checked, m_tdata[23:8],
                                              want.packet_number));
                if (m_tdata[24] !== want.packet_end)
                    report_mismatch($sformatf("result %0d packet end %0d, expected %0d",
                                              results_checked, m_tdata[24], want.packet_end));
                if (m_tdata[27:25] !== want.bundle_status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_checked, m_tdata[27:25],
                                              want.bundle_status));
                if (m_tlast !== want.result_last)
                    report_mismatch($sformatf("result %0d last %0d, expected %0d",
                                              results_checked, m_tlast, want.result_last));
            end
        end
        stall = 0;
        if (m_tvalid && m_tready && recv_gap_max > 0) begin
            stall = $urandom_range(0, recv_gap_max);
        end
        if (stall > 0) begin
            m_tready <= 1'b0;
            result_sink.hold = stall;
        end else if (result_sink.hold > 1) begin
            m_tready <= 1'b0;
            result_sink.hold = result_sink.hold - 1;
        end else begin
            m_tready <= 1'b1;
            result_sink.hold = 0;
        end
    end

    task automatic test_zero_count();
        bundle_q.delete();
        push_count(32'd0);
        send_bundle();
    endtask

    task automatic test_short_header();
        bundle_q.delete();
        bundle_q.push_back(8'hFF);
        send_bundle();
    endtask

    task automatic test_over_limit();
        bundle_q.delete();
        push_count(32'hFFFF_FFFF);
        bundle_q.push_back(8'h00);
        send_bundle();
    endtask

    task automatic test_empty_and_payload();
        bundle_q.delete();
        push_count(32'd2);
        bundle_q.push_back(8'h00);
        bundle_q.push_back(8'h00);
        bundle_q.push_back(8'h00);
        bundle_q.push_back(8'h02);
        bundle_q.push_back(8'hFF);
        bundle_q.push_back(8'h00);
        send_bundle();
    endtask

    task automatic test_truncated_length();
        bundle_q.delete();
        push_count(32'd1);
        bundle_q.push_back(8'h00);
        send_bundle();
    endtask

    task automatic run_traffic_phase(input logic [15:0] lim, input bit set_limit,
                                     input int sgap, input int rgap, input int n_bytes);
        int stop_at;
        wait_results_drained();
        if (set_limit) begin
            write_limit(lim);
        end
        check_limit_readback();
        send_gap_max = sgap;
        recv_gap_max = rgap;
        stop_at = items_sent + n_bytes;
        while (items_sent < stop_at) begin
            build_random_bundle();
            send_bundle();
            if ($urandom_range(0, 19) == 0) begin
                wait_results_drained();
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(LIMIT_RESET, 1'b0, 5, 5, 170);
        run_traffic_phase(16'd1, 1'b1, 0, 0, 170);
        run_traffic_phase(16'hFFFF, 1'b1, 5, 0, 170);
        run_traffic_phase(16'd0, 1'b1, 0, 5, 170);
        run_traffic_phase(16'($urandom_range(2, 6)), 1'b1, 5, 5, 170);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_count();
        test_short_header();
        test_over_limit();
        test_empty_and_payload();
        test_truncated_length();
        test_random_traffic();
        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (predicted_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      predicted_outputs.size()));
        end
        $display("Sent %0d bytes in %0d bundles and checked %0d results.",
                 items_sent, bundles_sent, results_checked);
        $display("Closing status counts: ok %0d, short %0d, over limit %0d,",
                 status_seen[0], status_seen[1], status_seen[2]);
        $display("cut length %0d, cut payload %0d.", status_seen[3], status_seen[4]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pbd_pkg.sv
rtl/core/pbd_parser.sv
rtl/core/pbd_result_fifo.sv
rtl/core/packet_bundle_deframer.sv
verif/packet_bundle_deframer_tb.sv
